[rtl/hlt_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and hash helpers for the L2/L3 hash learning table.
// No dependencies; used by every module of the block but the RAM, and by the checkers.
package hlt_pkg;

  localparam int MAC_W        = 48;
  localparam int IP_W         = 32;
  localparam int MAC_IDX_BITS = 8;
  localparam int MAC_SLOTS    = 1 << MAC_IDX_BITS;
  localparam int ROUTE_INDEX_BITS = 10;               // legal range 4..16
  localparam int ROUTE_SLOTS  = 1 << ROUTE_INDEX_BITS;
  localparam int ROUTE_SLOT_W = 10;                   // width of the result field
  localparam int COUNT_W      = 32;
  localparam int CLEAR_BITS   = (ROUTE_INDEX_BITS > MAC_IDX_BITS) ?
                                ROUTE_INDEX_BITS : MAC_IDX_BITS;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [MAC_W-1:0] source_mac;
    logic [IP_W-1:0]  source_ip;
    logic [IP_W-1:0]  dest_ip;
  } hdr_word_t;

  typedef struct packed {
    logic [MAC_IDX_BITS-1:0] mac_slot;
    logic                    mac_hit;
    logic [ROUTE_SLOT_W-1:0] route_slot;
    logic                    route_hit;
    logic [COUNT_W-1:0]      mac_learn_count;
    logic [COUNT_W-1:0]      route_learn_count;
  } res_word_t;

  // Clearing sweep status handed to the table logic.
  typedef struct packed {
    logic                  active;
    logic [CLEAR_BITS-1:0] addr;
  } sweep_t;

  // XOR of the first four MAC octets (first octet in bits 47:40).
  function automatic logic [MAC_IDX_BITS-1:0] mac_octet_xor(input logic [MAC_W-1:0] mac);
    return mac[47:40] ^ mac[39:32] ^ mac[31:24] ^ mac[23:16];
  endfunction

  // Fold the IP onto itself and keep the route index bits.
  function automatic logic [ROUTE_INDEX_BITS-1:0] route_fold(input logic [IP_W-1:0] ip);
    logic [15:0] fold;
    fold = ip[15:0] ^ ip[31:16];
    return fold[ROUTE_INDEX_BITS-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

[rtl/l2_l3_hash_learning_table.sv]
`timescale 1ns / 1ps
// L2/L3 hash learning table, top level.
// A header is registered in stage 1 with its table reads, then in the output register.
// Throughput: one header per cycle unless results stall; one read per word, write on a miss.
// Reset: synchronous; a clearing pass over max(256, route slots) addresses (1024 as built)
// zeroes both tables, with hdr_ready low until it finishes. Counters reset to zero.
module l2_l3_hash_learning_table (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hdr_valid,
  output logic                 hdr_ready,
  input  hlt_pkg::hdr_word_t   hdr,
  output logic                 res_valid,
  input  logic                 res_ready,
  output hlt_pkg::res_word_t   res
);

  localparam int RIB = hlt_pkg::ROUTE_INDEX_BITS;

  // ---------------------------------------------------------------------------
  // Clearing sweep
  // ---------------------------------------------------------------------------
  hlt_pkg::sweep_t sweep;

  hlt_clear_sweep u_sweep (
    .clk   (clk),
    .rst   (rst),
    .sweep (sweep)
  );

  // ---------------------------------------------------------------------------
  // Stage 0: hash the header and issue the table reads
  // ---------------------------------------------------------------------------
  logic                              accept;
  logic                              s1_adv;
  logic [hlt_pkg::MAC_IDX_BITS-1:0]  in_mac_slot;
  logic [RIB-1:0]                    in_route_idx;

  assign in_mac_slot  = hlt_pkg::mac_octet_xor(hdr.source_mac);
  assign in_route_idx = hlt_pkg::route_fold(hdr.source_ip);

  // Stage 1 holds one word; a new word enters when it is empty or drains this cycle, and not during the clearing pass.
  logic s1_valid;
  assign hdr_ready = !sweep.active && (!s1_valid || s1_adv);
  assign accept    = hdr_valid && hdr_ready;

  // ---------------------------------------------------------------------------
  // Stage 1 registers: word in flight, read data, forwarding of last write-back
  // ---------------------------------------------------------------------------
  logic [hlt_pkg::MAC_IDX_BITS-1:0] s1_mac_slot;
  logic [RIB-1:0]                   s1_route_idx;
  logic [hlt_pkg::MAC_W-1:0]        s1_mac;
  logic [hlt_pkg::IP_W-1:0]         s1_dip;
  logic                             fwd_mac_valid;
  logic [hlt_pkg::MAC_W-1:0]        fwd_mac;
  logic                             fwd_route_valid;
  logic [hlt_pkg::IP_W-1:0]         fwd_route;
  logic [hlt_pkg::MAC_W-1:0]        mac_rd;
  logic [hlt_pkg::IP_W-1:0]         route_rd;

  // Looked-up entries; the previous word's write-back lands on the same edge
  // as this word's read, so the RAM returns stale data and we forward instead.
  logic [hlt_pkg::MAC_W-1:0] mac_entry;
  logic [hlt_pkg::IP_W-1:0]  route_entry;
  logic                      mac_hit;
  logic                      route_hit;
  logic                      mac_learn;
  logic                      route_learn;

  assign mac_entry   = fwd_mac_valid   ? fwd_mac   : mac_rd;
  assign route_entry = fwd_route_valid ? fwd_route : route_rd;
  // L2 occupancy is keyed on the stored first octet only.
  assign mac_hit     = mac_entry[47:40] != 8'h00;
  assign route_hit   = route_entry != '0;

  assign s1_adv      = s1_valid && (!res_valid || res_ready);
  assign mac_learn   = s1_adv && !mac_hit;
  assign route_learn = s1_adv && !route_hit;

  // ---------------------------------------------------------------------------
  // Table RAMs; the sweep owns the write ports until it is done
  // ---------------------------------------------------------------------------
  logic                             mac_we;
  logic [hlt_pkg::MAC_IDX_BITS-1:0] mac_waddr;
  logic [hlt_pkg::MAC_W-1:0]        mac_wdata;
  logic                             route_we;
  logic [RIB-1:0]                   route_waddr;
  logic [hlt_pkg::IP_W-1:0]         route_wdata;

  assign mac_we      = sweep.active || mac_learn;
  assign mac_waddr   = sweep.active ? sweep.addr[hlt_pkg::MAC_IDX_BITS-1:0] : s1_mac_slot;
  assign mac_wdata   = sweep.active ? '0 : s1_mac;
  assign route_we    = sweep.active || route_learn;
  assign route_waddr = sweep.active ? sweep.addr[RIB-1:0] : s1_route_idx;
  assign route_wdata = sweep.active ? '0 : s1_dip;

  hlt_ram #(
    .WIDTH (hlt_pkg::MAC_W),
    .AW    (hlt_pkg::MAC_IDX_BITS)
  ) u_mac_ram (
    .clk   (clk),
    .we    (mac_we),
    .waddr (mac_waddr),
    .wdata (mac_wdata),
    .re    (accept),
    .raddr (in_mac_slot),
    .rdata (mac_rd)
  );

  hlt_ram #(
    .WIDTH (hlt_pkg::IP_W),
    .AW    (RIB)
  ) u_route_ram (
    .clk   (clk),
    .we    (route_we),
    .waddr (route_waddr),
    .wdata (route_wdata),
    .re    (accept),
    .raddr (in_route_idx),
    .rdata (route_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 1 control and forwarding
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      fwd_mac_valid   <= 1'b0;
      fwd_route_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid        <= 1'b1;
        fwd_mac_valid   <= mac_learn && (in_mac_slot == s1_mac_slot);
        fwd_route_valid <= route_learn && (in_route_idx == s1_route_idx);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mac_slot  <= in_mac_slot;
      s1_route_idx <= in_route_idx;
      s1_mac       <= hdr.source_mac;
      s1_dip       <= hdr.dest_ip;
      fwd_mac      <= s1_mac;
      fwd_route    <= s1_dip;
    end
  end

  // ---------------------------------------------------------------------------
  // Saturating learn counters
  // ---------------------------------------------------------------------------
  logic [hlt_pkg::COUNT_W-1:0] mac_learns;
  logic [hlt_pkg::COUNT_W-1:0] route_learns;
  logic [hlt_pkg::COUNT_W-1:0] mac_learns_next;
  logic [hlt_pkg::COUNT_W-1:0] route_learns_next;

  assign mac_learns_next   = mac_learn   ? hlt_pkg::sat_inc(mac_learns)   : mac_learns;
  assign route_learns_next = route_learn ? hlt_pkg::sat_inc(route_learns) : route_learns;

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_learns   <= '0;
      route_learns <= '0;
    end else begin
      mac_learns   <= mac_learns_next;
      route_learns <= route_learns_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res.mac_slot          <= s1_mac_slot;
      res.mac_hit           <= mac_hit;
      res.route_slot        <= hlt_pkg::ROUTE_SLOT_W'(s1_route_idx);
      res.route_hit         <= route_hit;
      res.mac_learn_count   <= mac_learns_next;
      res.route_learn_count <= route_learns_next;
    end
  end

endmodule

[rtl/hlt_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hlt_ram #(
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on an address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/hlt_clear_sweep.sv]
`timescale 1ns / 1ps
// Post-reset clearing pass: walks every address of the larger table once, one per cycle.
// Depends on hlt_pkg.
module hlt_clear_sweep (
  input  logic            clk,
  input  logic            rst,
  output hlt_pkg::sweep_t sweep
);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep.active <= 1'b1;
      sweep.addr   <= '0;
    end else if (sweep.active) begin
      sweep.addr <= sweep.addr + hlt_pkg::CLEAR_BITS'(1);
      if (sweep.addr == {hlt_pkg::CLEAR_BITS{1'b1}}) begin
        sweep.active <= 1'b0;
      end
    end
  end

endmodule

[rtl/hlt_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the L2/L3 hash learning table, bound to the top level.
// Depends on hlt_pkg.
module hlt_checker (
  input logic               clk,
  input logic               rst,
  input logic               hdr_valid,
  input logic               hdr_ready,
  input hlt_pkg::hdr_word_t hdr,
  input logic               res_valid,
  input logic               res_ready,
  input hlt_pkg::res_word_t res
);

  logic                        res_take;
  logic [hlt_pkg::COUNT_W-1:0] last_mac_cnt;
  logic [hlt_pkg::COUNT_W-1:0] last_route_cnt;
  logic [hlt_pkg::COUNT_W-1:0] exp_mac_cnt;
  logic [hlt_pkg::COUNT_W-1:0] exp_route_cnt;

  assign res_take      = res_valid && res_ready;
  assign exp_mac_cnt   = res.mac_hit   ? last_mac_cnt   : hlt_pkg::sat_inc(last_mac_cnt);
  assign exp_route_cnt = res.route_hit ? last_route_cnt : hlt_pkg::sat_inc(last_route_cnt);

  // counts seen on the previous result word
  always_ff @(posedge clk) begin
    if (rst) begin
      last_mac_cnt   <= '0;
      last_route_cnt <= '0;
    end else if (res_take) begin
      last_mac_cnt   <= res.mac_learn_count;
      last_route_cnt <= res.route_learn_count;
    end
  end

  a_hdr_hold: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr))
    else $error("header word changed or dropped while waiting");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed or dropped while stalled");

  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !hdr_ready)
    else $error("header accepted before clearing pass");

  a_mac_count: assert property (@(posedge clk) disable iff (rst)
    res_take |-> res.mac_learn_count == exp_mac_cnt)
    else $error("L2 learn count does not follow hit flags");

  a_route_count: assert property (@(posedge clk) disable iff (rst)
    res_take |-> res.route_learn_count == exp_route_cnt)
    else $error("L3 learn count does not follow hit flags");

endmodule

bind l2_l3_hash_learning_table hlt_checker u_hlt_checker (
  .clk       (clk),
  .rst       (rst),
  .hdr_valid (hdr_valid),
  .hdr_ready (hdr_ready),
  .hdr       (hdr),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

[tb/learning_table_checker.sv]
`timescale 1ns / 1ps
// Checker for the L2/L3 hash learning table: tracks both tables, predicts each result word.
// Depends on hlt_pkg for the word types and table sizes.
module learning_table_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               hdr_valid,
  input  logic               hdr_ready,
  input  hlt_pkg::hdr_word_t hdr,
  input  logic               res_valid,
  input  logic               res_ready,
  input  hlt_pkg::res_word_t res,
  output int                 mismatches,
  output int                 pending,
  output int                 checked,
  output int                 mac_hits_seen,
  output int                 route_hits_seen
);

  localparam int CW = hlt_pkg::COUNT_W;

  logic [hlt_pkg::MAC_W-1:0]   mac_table   [hlt_pkg::MAC_SLOTS];
  logic [hlt_pkg::IP_W-1:0]    route_table [hlt_pkg::ROUTE_SLOTS];
  logic [CW-1:0]               mac_learns;
  logic [CW-1:0]               route_learns;
  hlt_pkg::res_word_t          expected_results [$];

  // One header word: look up both tables, learn on a miss, return the result word.
  function automatic hlt_pkg::res_word_t lookup_and_learn(hlt_pkg::hdr_word_t h);
    hlt_pkg::res_word_t                   r;
    logic [hlt_pkg::MAC_IDX_BITS-1:0]     ms;
    logic [15:0]                          folded;
    logic [hlt_pkg::ROUTE_INDEX_BITS-1:0] rs;
    ms = h.source_mac[47:40] ^ h.source_mac[39:32] ^ h.source_mac[31:24] ^
         h.source_mac[23:16];
    r.mac_slot = ms;
    // occupancy is judged on the first octet only
    r.mac_hit = (mac_table[ms][47:40] != 8'h00);
    if (!r.mac_hit) begin
      mac_table[ms] = h.source_mac;
      if (~mac_learns != '0) mac_learns = mac_learns + 1'b1;
    end
    folded = h.source_ip[31:16] ^ h.source_ip[15:0];
    rs = folded[hlt_pkg::ROUTE_INDEX_BITS-1:0];
    r.route_slot = hlt_pkg::ROUTE_SLOT_W'(rs);
    r.route_hit = (route_table[rs] != '0);
    if (!r.route_hit) begin
      route_table[rs] = h.dest_ip;
      if (~route_learns != '0) route_learns = route_learns + 1'b1;
    end
    r.mac_learn_count   = mac_learns;
    r.route_learn_count = route_learns;
    return r;
  endfunction

  task automatic compare_field(string name, logic [CW-1:0] exp, logic [CW-1:0] got);
    if (exp !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    hlt_pkg::res_word_t e;
    if (rst) begin
      for (int i = 0; i < hlt_pkg::MAC_SLOTS; i++) mac_table[i] = '0;
      for (int i = 0; i < hlt_pkg::ROUTE_SLOTS; i++) route_table[i] = '0;
      mac_learns   = '0;
      route_learns = '0;
      expected_results.delete();
      mismatches      = 0;
      checked         = 0;
      mac_hits_seen   = 0;
      route_hits_seen = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing outstanding: slot 0x%0h", res.mac_slot);
          mismatches++;
        end else begin
          e = expected_results.pop_front();
          compare_field("mac_slot", CW'(e.mac_slot), CW'(res.mac_slot));
          compare_field("mac_hit", CW'(e.mac_hit), CW'(res.mac_hit));
          compare_field("route_slot", CW'(e.route_slot), CW'(res.route_slot));
          compare_field("route_hit", CW'(e.route_hit), CW'(res.route_hit));
          compare_field("mac_learn_count", e.mac_learn_count, res.mac_learn_count);
          compare_field("route_learn_count", e.route_learn_count, res.route_learn_count);
          checked++;
          if (e.mac_hit) mac_hits_seen++;
          if (e.route_hit) route_hits_seen++;
        end
      end
      if (hdr_valid && hdr_ready) begin
        expected_results.insert(expected_results.size(), lookup_and_learn(hdr));
      end
    end
    pending = expected_results.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the testbench for the L2/L3 hash learning table: clock, reset, header stimulus,
// result back-pressure and verdict. Depends on hlt_pkg, the top level and learning_table_checker.
module testbench;

  localparam int CYCLE_LIMIT = 200000;  // watchdog limit for the whole run
  localparam int HOLD_CYCLES = 400;     // long receiver stall, fills the pipeline
  localparam int TAIL_CYCLES = 10;      // margin after drain
  localparam int PHASE_WORDS = 345;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               hdr_valid = 1'b0;
  logic               hdr_ready;
  hlt_pkg::hdr_word_t hdr       = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  hlt_pkg::res_word_t res;

  int mismatches, pending, checked, mac_hits_seen, route_hits_seen;
  int send_idle_pct = 16;
  int recv_idle_pct = 86;
  int words_sent    = 0;
  int cycle_count   = 0;
  int hold_left     = 0;
  bit hold_request  = 1'b0;

  // Addresses reused so that lookups hit as well as learn.
  logic [hlt_pkg::MAC_W-1:0] mac_pool [16];
  logic [hlt_pkg::IP_W-1:0]  ip_pool  [16];

  always #2 clk = ~clk;

  l2_l3_hash_learning_table dut (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr       (hdr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  learning_table_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .hdr_valid       (hdr_valid),
    .hdr_ready       (hdr_ready),
    .hdr             (hdr),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .mismatches      (mismatches),
    .pending         (pending),
    .checked         (checked),
    .mac_hits_seen   (mac_hits_seen),
    .route_hits_seen (route_hits_seen)
  );

  // Watchdog: also covers the clearing pass after reset.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off counted here on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high between back-to-back words,
  // so each step sees a single assignment to it.
  task automatic send_word(hlt_pkg::hdr_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      hdr_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    hdr_valid <= 1'b1;
    hdr       <= w;
    @(posedge clk);
    while (!hdr_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(logic [hlt_pkg::MAC_W-1:0] mac,
                             logic [hlt_pkg::IP_W-1:0] sip,
                             logic [hlt_pkg::IP_W-1:0] dip);
    hlt_pkg::hdr_word_t w;
    w.source_mac = mac;
    w.source_ip  = sip;
    w.dest_ip    = dip;
    send_word(w);
  endtask

  // Mix of reused and fresh addresses; zero first octets and zero next hops kept common
  // so the never-occupied paths stay busy after the tables fill.
  function automatic hlt_pkg::hdr_word_t random_header();
    hlt_pkg::hdr_word_t w;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      w.source_mac = mac_pool[$urandom_range(0, 15)];
    else                w.source_mac = {16'($urandom), $urandom};
    if (pick >= 30 && pick < 50) w.source_mac[47:40] = 8'h00;
    pick = $urandom_range(0, 99);
    if (pick < 35)      w.source_ip = ip_pool[$urandom_range(0, 15)];
    else                w.source_ip = $urandom;
    w.dest_ip = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
    return w;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_word(random_header());
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      mac_pool[i] = {16'($urandom), $urandom};
      ip_pool[i]  = $urandom;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes and the corner cases of both tables.
    send_header(48'hFFFF_FFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);  // learn both, slot 0
    send_header(48'hFFFF_FFFF_1234, 32'hFFFF_FFFF, 32'h1111_1111);  // hit on differing MAC/IP
    send_header(48'h0000_0000_0000, 32'h0000_03FF, 32'h0000_0001);  // all-zero MAC
    send_header(48'h0000_0000_0000, 32'hFFFF_0000, 32'h0000_0002);  // slot 0 hit again, slot 0x3FF hit
    send_header(48'h0012_3456_789A, 32'h0001_0000, 32'h0000_0000);  // zero octet, zero next hop
    send_header(48'h0012_3456_0000, 32'h0001_0000, 32'hC0A8_0001);  // both relearn
    send_header(48'h0012_3456_FFFF, 32'h0001_0000, 32'h0A00_0001);  // MAC learns again, L3 hit
    send_header(48'h8000_0000_0000, 32'hFC00_0000, 32'h8000_0000);  // top bits only
    send_header(48'h0100_0000_0000, 32'h0000_FC00, 32'h0000_0000);  // fold ignores bits 15:10
    send_header(48'h0000_0001_0000, 32'h8000_8000, 32'h7FFF_FFFF);
    send_header(48'hAA55_AA55_0000, 32'h1234_5678, 32'hDEAD_BEEF);  // hash to zero, slot taken
    send_header(48'h55AA_55AA_FFFF, 32'h1234_5678, 32'h0BAD_F00D);
    send_header(48'h0102_0408_1020, 32'h0000_0001, 32'h0000_0001);
    send_header(48'h0102_0408_FFFF, 32'h0001_0001, 32'h0000_0003);  // fold to zero, hit
    send_header(48'hFEDC_BA98_7654, 32'h7FFF_FFFF, 32'hFFFF_FFFE);

    send_random(PHASE_WORDS);

    send_idle_pct = 86;
    recv_idle_pct = 16;
    send_random(PHASE_WORDS);

    // No idling; one long receiver stall while words keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    send_random(PHASE_WORDS);

    hdr_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d header words over three back-pressure phases and one long stall.",
             words_sent);
    $display("Checked %0d results: %0d L2 hits, %0d L3 hits, %0d mismatches.",
             checked, mac_hits_seen, route_hits_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/hlt_pkg.sv
rtl/hlt_ram.sv
rtl/hlt_clear_sweep.sv
rtl/l2_l3_hash_learning_table.sv
rtl/hlt_checker.sv
tb/learning_table_checker.sv
tb/testbench.sv
